/* hdl/ulsc_pkg.sv */
package ulsc_pkg;

  // Field widths fixed by the item formats
  localparam int REQ_W   = 1;
  localparam int CNT_W   = 16;
  localparam int LED_W   = 5;
  localparam int FREQ_W  = 22;
  localparam int ROC_W   = 24;
  localparam int HOLD_W  = 16;
  localparam int TICK_W  = 32;
  localparam int DIV_W   = 32;

  // Load count default and its allowed ceiling
  localparam int NUM_LOADS_DEF = 5;
  localparam int MAX_LOADS     = 16;

  // Arithmetic constants: 16 kHz analyser rate in 1/256 Hz units
  localparam logic [FREQ_W-1:0] FREQ_SAT = 22'h3FFFFF;
  localparam logic [ROC_W-1:0]  ROC_SAT  = 24'hFFFFFF;
  localparam logic [DIV_W-1:0]  FREQ_NUM = 32'd4096000;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK   = 1'b0;
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_TH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROC_TH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN     = 2'd3;

  // Configuration reset values
  localparam logic [FREQ_W-1:0] FREQ_TH_RST = 22'd12800;
  localparam logic [ROC_W-1:0]  ROC_TH_RST  = 24'd1280;
  localparam logic [HOLD_W-1:0] HOLD_RST    = 16'd500;
  localparam logic              RUN_RST     = 1'b1;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [CNT_W-1:0] period_count;
    logic [LED_W-1:0] switches;
  } in_item_t;

  typedef struct packed {
    logic [LED_W-1:0]  load_bank;
    logic [LED_W-1:0]  red_leds;
    logic [LED_W-1:0]  green_leds;
    logic              stable;
    logic [FREQ_W-1:0] frequency;
    logic [ROC_W-1:0]  rate_of_change;
  } out_item_t;

  // Serial divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

/* hdl/ulsc_stream_if.sv */
interface ulsc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/ulsc_div.sv */
module ulsc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ulsc_pkg::div_req_t req,
  output ulsc_pkg::div_rsp_t rsp
);

  localparam int W    = ulsc_pkg::DIV_W;
  localparam int CW   = $clog2(W);

  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    trial;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem_r, quo_r[W-1]} - {1'b0, den_r};

  // Control: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: numerator shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_r <= trial[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[W-2:0], quo_r[W-1]};
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

/* hdl/underfreq_load_shed_controller_top.sv */
// Channel  | Direction | Payload                                          | Handshake
// in_chan  | in        | req_type, period_count, switches                 | valid/ready
// out_chan | out       | load_bank, red/green_leds, stable, freq, roc     | valid/ready
// cfg_*    | in        | cfg_idx selects register, cfg_wdata value        | cfg_we only
//
// A tick or an ignored sample passes only through accept and result load.
// A run-mode sample runs two 32-step divisions (frequency, then rate of
// change) on one shared bit-serial divider; a zero count, a first sample
// or a second sample in the same tick skips one division, and both can be skipped.
// One item at a time; a stalled output holds the next result in its final step.
// rst_n is synchronous, active low; it restores configuration and controller state, not working or result data.
module underfreq_load_shed_controller_top #(
  parameter int NUM_LOADS = ulsc_pkg::NUM_LOADS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  ulsc_stream_if.sink                         in_chan,
  ulsc_stream_if.source                       out_chan,
  input  logic                                cfg_we,
  input  logic [ulsc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [ulsc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int FREQ_W = ulsc_pkg::FREQ_W;
  localparam int ROC_W  = ulsc_pkg::ROC_W;
  localparam int TICK_W = ulsc_pkg::TICK_W;
  localparam int HOLD_W = ulsc_pkg::HOLD_W;
  localparam int LED_W  = ulsc_pkg::LED_W;
  localparam int DIV_W  = ulsc_pkg::DIV_W;
  localparam int SC_W   = $clog2(NUM_LOADS + 1);
  localparam int BW     = (NUM_LOADS > LED_W) ? NUM_LOADS : LED_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIVF   = 3'd1;
  localparam logic [2:0] ST_DIFF   = 3'd2;
  localparam logic [2:0] ST_PREP   = 3'd3;
  localparam logic [2:0] ST_DIVR   = 3'd4;
  localparam logic [2:0] ST_DECIDE = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  // Configuration registers
  logic [FREQ_W-1:0] freq_th_r;
  logic [ROC_W-1:0]  roc_th_r;
  logic [HOLD_W-1:0] hold_r;
  logic              run_r;

  // Controller state
  logic [2:0]           state_r;
  logic [TICK_W-1:0]    tick_now_r;
  logic [NUM_LOADS-1:0] bank_r;
  logic [SC_W-1:0]      shed_cnt_r;
  logic                 last_unstable_r;
  logic [TICK_W-1:0]    action_time_r;
  logic [FREQ_W-1:0]    prev_freq_r;
  logic [TICK_W-1:0]    prev_time_r;
  logic                 have_prev_r;
  logic [ROC_W-1:0]     last_roc_r;

  // Per-item working registers
  logic [LED_W-1:0]  sw_r;
  logic [FREQ_W-1:0] f_r;
  logic [ROC_W-1:0]  roc_r;
  logic [FREQ_W-1:0] diff_r;
  logic [TICK_W-1:0] dt_r;

  // Result register
  ulsc_pkg::out_item_t out_r;
  ulsc_pkg::out_item_t out_nxt;
  logic                out_valid_r;

  ulsc_pkg::div_req_t div_req;
  ulsc_pkg::div_rsp_t div_rsp;

  logic              in_xfer;
  logic              out_free;
  logic              is_sample;
  logic [DIV_W-1:0]  diff_x1000;
  logic              unstable;
  logic [TICK_W-1:0] elapsed;
  logic              hold_over;
  logic              can_shed;
  logic              can_restore;
  logic [BW-1:0]     bank_wide;
  logic [BW-1:0]     load_mask;
  logic [LED_W-1:0]  red_w;

  ulsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign is_sample     = (in_chan.data.req_type == ulsc_pkg::REQ_SAMPLE);
  assign out_free      = !out_valid_r || out_chan.ready;

  // diff * 1000 as diff * 1024 - diff * 16 - diff * 8
  assign diff_x1000 = (DIV_W'(diff_r) << 10) - (DIV_W'(diff_r) << 4) - (DIV_W'(diff_r) << 3);

  // Start the divider for frequency on accept of a run-mode sample with a nonzero count, for rate in the prep step
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = ulsc_pkg::FREQ_NUM;
    div_req.den   = DIV_W'(in_chan.data.period_count);
    if (in_xfer && is_sample && run_r && (in_chan.data.period_count != '0)) begin
      div_req.start = 1'b1;
    end else if (state_r == ST_PREP) begin
      div_req.num   = diff_x1000;
      div_req.den   = dt_r;
      div_req.start = have_prev_r && (dt_r != '0);
    end
  end

  // Stability decision and hold timing
  assign unstable    = (f_r < freq_th_r) || (roc_r > roc_th_r);
  assign elapsed     = tick_now_r - action_time_r;
  assign hold_over   = elapsed > TICK_W'(hold_r);
  assign can_shed    = shed_cnt_r < SC_W'(NUM_LOADS);
  assign can_restore = shed_cnt_r != '0;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_th_r <= ulsc_pkg::FREQ_TH_RST;
      roc_th_r  <= ulsc_pkg::ROC_TH_RST;
      hold_r    <= ulsc_pkg::HOLD_RST;
      run_r     <= ulsc_pkg::RUN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        ulsc_pkg::CFG_FREQ_TH: freq_th_r <= cfg_wdata[FREQ_W-1:0];
        ulsc_pkg::CFG_ROC_TH:  roc_th_r  <= cfg_wdata[ROC_W-1:0];
        ulsc_pkg::CFG_HOLD:    hold_r    <= cfg_wdata[HOLD_W-1:0];
        ulsc_pkg::CFG_RUN:     run_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      tick_now_r      <= '0;
      bank_r          <= '1;
      shed_cnt_r      <= '0;
      last_unstable_r <= 1'b0;
      action_time_r   <= '0;
      prev_freq_r     <= '0;
      prev_time_r     <= '0;
      have_prev_r     <= 1'b0;
      last_roc_r      <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (!is_sample) begin
              tick_now_r <= tick_now_r + 1'b1;
              state_r    <= ST_EMIT;
            end else if (!run_r) begin
              state_r <= ST_EMIT;
            end else if (in_chan.data.period_count == '0) begin
              state_r <= ST_DIFF;
            end else begin
              state_r <= ST_DIVF;
            end
          end
        end
        ST_DIVF: begin
          if (div_rsp.done) begin
            state_r <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          state_r <= ST_PREP;
        end
        ST_PREP: begin
          if (have_prev_r && (dt_r != '0)) begin
            state_r <= ST_DIVR;
          end else begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DIVR: begin
          if (div_rsp.done) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          prev_freq_r     <= f_r;
          prev_time_r     <= tick_now_r;
          have_prev_r     <= 1'b1;
          last_roc_r      <= roc_r;
          last_unstable_r <= unstable;
          if (unstable) begin
            if (!last_unstable_r) begin
              // Edge sheds only from a full bank
              if ((&bank_r) && can_shed) begin
                bank_r     <= bank_r & ~(NUM_LOADS'(1) << shed_cnt_r);
                shed_cnt_r <= shed_cnt_r + 1'b1;
              end
              action_time_r <= tick_now_r;
            end else if (hold_over) begin
              if ((|bank_r) && can_shed) begin
                bank_r     <= bank_r & ~(NUM_LOADS'(1) << shed_cnt_r);
                shed_cnt_r <= shed_cnt_r + 1'b1;
              end
              action_time_r <= tick_now_r;
            end
          end else begin
            if (last_unstable_r) begin
              action_time_r <= tick_now_r;
            end else if (hold_over) begin
              // Restore last shed load first
              if (!(&bank_r) && can_restore) begin
                bank_r     <= bank_r | (NUM_LOADS'(1) << (shed_cnt_r - 1'b1));
                shed_cnt_r <= shed_cnt_r - 1'b1;
              end
              action_time_r <= tick_now_r;
            end
          end
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Working registers for one sample
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sw_r  <= in_chan.data.switches;
      f_r   <= ulsc_pkg::FREQ_SAT;
      roc_r <= '0;
    end
    if ((state_r == ST_DIVF) && div_rsp.done) begin
      f_r <= div_rsp.quot[FREQ_W-1:0];
    end
    if (state_r == ST_DIFF) begin
      diff_r <= (f_r >= prev_freq_r) ? (f_r - prev_freq_r) : (prev_freq_r - f_r);
      dt_r   <= tick_now_r - prev_time_r;
    end
    if ((state_r == ST_PREP) && have_prev_r && (dt_r == '0)) begin
      roc_r <= (diff_r == '0) ? '0 : ulsc_pkg::ROC_SAT;
    end
    if ((state_r == ST_DIVR) && div_rsp.done) begin
      roc_r <= (|div_rsp.quot[DIV_W-1:ROC_W]) ? ulsc_pkg::ROC_SAT
                                               : div_rsp.quot[ROC_W-1:0];
    end
  end

  // Assemble the result from current state
  assign bank_wide = BW'(bank_r);
  assign load_mask = BW'({NUM_LOADS{1'b1}});
  assign red_w     = sw_r & bank_wide[LED_W-1:0];

  always_comb begin
    out_nxt.load_bank      = bank_wide[LED_W-1:0];
    out_nxt.red_leds       = red_w;
    out_nxt.green_leds     = ~red_w & sw_r & load_mask[LED_W-1:0];
    out_nxt.stable         = ~last_unstable_r;
    out_nxt.frequency      = prev_freq_r;
    out_nxt.rate_of_change = last_roc_r;
  end

  // Result register: load on the final step, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && out_free) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

endmodule

/* tb/underfreq_load_shed_controller_top_tb.sv */
module underfreq_load_shed_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ulsc_pkg::*;

  localparam int LOADS = NUM_LOADS_DEF;
  localparam logic [LED_W-1:0] EVERY_LOAD = LED_W'((1 << LOADS) - 1);
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 80;
  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 270;
  localparam int MAINT_ITEMS = 60;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
    in_item_t              item;
    logic                  typed;
    out_item_t             want;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ulsc_stream_if #(.T(in_item_t))  in_chan ();
  ulsc_stream_if #(.T(out_item_t)) out_chan ();

  underfreq_load_shed_controller_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Register copies
  logic [FREQ_W-1:0] freq_limit;
  logic [ROC_W-1:0]  roc_limit;
  logic [HOLD_W-1:0] hold_limit;
  logic              running;

  // Relay state copies
  logic [TICK_W-1:0] now_ms;
  logic [TICK_W-1:0] last_action_ms;
  logic [TICK_W-1:0] last_sample_ms;
  logic [LED_W-1:0]  loads_on;
  int unsigned       loads_shed;
  logic              was_unstable;
  logic              seen_sample;
  logic [FREQ_W-1:0] last_freq;
  logic [ROC_W-1:0]  last_roc;

  out_item_t   pending_status [$];
  script_row_t script [$];

  int mismatches = 0;
  int results_seen = 0;
  int cycle_count = 0;
  bit hold_off_req = 1'b0;
  bit burst_mode = 1'b0;
  bit sagging = 1'b0;
  int nominal = 320;
  int last_count = 320;

  function automatic void reset_relay_shadow();
    freq_limit     = FREQ_TH_RST;
    roc_limit      = ROC_TH_RST;
    hold_limit     = HOLD_RST;
    running        = RUN_RST;
    now_ms         = '0;
    last_action_ms = '0;
    last_sample_ms = '0;
    loads_on       = EVERY_LOAD;
    loads_shed     = 0;
    was_unstable   = 1'b0;
    seen_sample    = 1'b0;
    last_freq      = '0;
    last_roc       = '0;
  endfunction

  function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_FREQ_TH: freq_limit = v[FREQ_W-1:0];
      CFG_ROC_TH:  roc_limit  = v[ROC_W-1:0];
      CFG_HOLD:    hold_limit = v[HOLD_W-1:0];
      CFG_RUN:     running    = v[0];
      default: ;
    endcase
  endfunction

  // Disconnect the lowest-priority load still on
  function automatic void drop_load();
    if (loads_shed < LOADS) begin
      loads_on[loads_shed] = 1'b0;
      loads_shed++;
    end
  endfunction

  function automatic void measure_sample(input logic [CNT_W-1:0] cnt);
    logic [DIV_W-1:0] f;
    logic [DIV_W-1:0] diff;
    logic [DIV_W-1:0] dt;
    logic [DIV_W-1:0] elapsed;
    logic [63:0]      scaled;
    logic [ROC_W-1:0] roc;
    logic             hot;
    // Frequency, saturating on a zero count
    f = (cnt == '0) ? DIV_W'(FREQ_SAT) : FREQ_NUM / DIV_W'(cnt);
    if (f > DIV_W'(FREQ_SAT))
      f = DIV_W'(FREQ_SAT);
    // Absolute rate of change against the previous sample
    roc = '0;
    if (seen_sample) begin
      diff = (f >= DIV_W'(last_freq)) ? f - DIV_W'(last_freq) : DIV_W'(last_freq) - f;
      dt = now_ms - last_sample_ms;
      if (dt == '0) begin
        roc = (diff == '0) ? '0 : ROC_SAT;
      end else begin
        scaled = (64'(diff) * 64'd1000) / 64'(dt);
        roc = (scaled > 64'(ROC_SAT)) ? ROC_SAT : scaled[ROC_W-1:0];
      end
    end
    last_freq      = f[FREQ_W-1:0];
    last_sample_ms = now_ms;
    seen_sample    = 1'b1;
    last_roc       = roc;
    // Shed on the unstable edge from a full bank or after each hold; restore after each stable hold
    hot = (f < DIV_W'(freq_limit)) || (roc > roc_limit);
    elapsed = now_ms - last_action_ms;
    if (hot) begin
      if (!was_unstable) begin
        if (loads_on == EVERY_LOAD)
          drop_load();
        last_action_ms = now_ms;
      end else if (elapsed > DIV_W'(hold_limit)) begin
        if (loads_on != '0)
          drop_load();
        last_action_ms = now_ms;
      end
    end else begin
      if (was_unstable) begin
        last_action_ms = now_ms;
      end else if (elapsed > DIV_W'(hold_limit)) begin
        if (loads_on != EVERY_LOAD && loads_shed > 0) begin
          loads_shed--;
          loads_on[loads_shed] = 1'b1;
        end
        last_action_ms = now_ms;
      end
    end
    was_unstable = hot;
  endfunction

  function automatic out_item_t relay_status_after(input in_item_t it);
    out_item_t        st;
    logic [LED_W-1:0] lit;
    if (it.req_type == REQ_TICK)
      now_ms = now_ms + 1'b1;
    else if (running)
      measure_sample(it.period_count);
    lit = it.switches & loads_on;
    st.load_bank      = loads_on;
    st.red_leds       = lit;
    st.green_leds     = ~lit & it.switches & EVERY_LOAD;
    st.stable         = ~was_unstable;
    st.frequency      = last_freq;
    st.rate_of_change = last_roc;
    return st;
  endfunction

  // Mostly ticks and samples around the nominal count, drifting between a
  // healthy and a sagging band; a few samples with any count at all
  function automatic in_item_t draw_relay_item();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.switches = LED_W'($urandom);
    it.req_type = (pick < 55) ? REQ_TICK : REQ_SAMPLE;
    if (pick >= 93) begin
      it.period_count = (pick == 99) ? '0 : CNT_W'($urandom);
    end else begin
      if ($urandom_range(0, 9) == 0)
        sagging = ~sagging;
      if ($urandom_range(0, 2) == 0) begin
        if (sagging)
          last_count = nominal + 1 + $urandom_range(0, 39);
        else
          last_count = nominal - $urandom_range(0, 4);
      end
      it.period_count = CNT_W'(last_count);
    end
    return it;
  endfunction

  function automatic script_row_t item_row(input logic [REQ_W-1:0] req,
                                           input logic [CNT_W-1:0] cnt,
                                           input logic [LED_W-1:0] sw);
    script_row_t r;
    r = '0;
    r.item.req_type     = req;
    r.item.period_count = cnt;
    r.item.switches     = sw;
    return r;
  endfunction

  function automatic script_row_t typed_row(
    input logic [REQ_W-1:0] req, input logic [CNT_W-1:0] cnt, input logic [LED_W-1:0] sw,
    input logic [LED_W-1:0] bank, input logic [LED_W-1:0] red, input logic [LED_W-1:0] green,
    input logic steady, input logic [FREQ_W-1:0] freq, input logic [ROC_W-1:0] roc);
    script_row_t r;
    r = item_row(req, cnt, sw);
    r.typed               = 1'b1;
    r.want.load_bank      = bank;
    r.want.red_leds       = red;
    r.want.green_leds     = green;
    r.want.stable         = steady;
    r.want.frequency      = freq;
    r.want.rate_of_change = roc;
    return r;
  endfunction

  function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] v);
    script_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.wdata  = v;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
               what, got, want, results_seen);
  endtask

  task automatic check_status(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (pending_status.size() == 0) begin
      flag_mismatch("result with nothing pending", 32'(got.load_bank), '0);
      return;
    end
    want = pending_status.pop_front();
    if (got.load_bank !== want.load_bank)
      flag_mismatch("load_bank", 32'(got.load_bank), 32'(want.load_bank));
    if (got.red_leds !== want.red_leds)
      flag_mismatch("red_leds", 32'(got.red_leds), 32'(want.red_leds));
    if (got.green_leds !== want.green_leds)
      flag_mismatch("green_leds", 32'(got.green_leds), 32'(want.green_leds));
    if (got.stable !== want.stable)
      flag_mismatch("stable", 32'(got.stable), 32'(want.stable));
    if (got.frequency !== want.frequency)
      flag_mismatch("frequency", 32'(got.frequency), 32'(want.frequency));
    if (got.rate_of_change !== want.rate_of_change)
      flag_mismatch("rate_of_change", 32'(got.rate_of_change), 32'(want.rate_of_change));
  endtask

  // Offer one item after a random gap (none in burst mode); predict once the transfer happens
  task automatic offer(input in_item_t it, input logic typed, input out_item_t want);
    int        gap;
    out_item_t status;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= it;
    do @(posedge clk); while (!in_chan.ready);
    status = relay_status_after(it);
    pending_status.push_back(typed ? want : status);
  endtask

  task automatic idle_input();
    in_chan.valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_register(idx, v);
    @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int stall;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 8);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_chan.ready <= 1'b0;
        for (int c = 0; c < HOLD_OFF_CYCLES; c++)
          @(posedge clk);
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      check_status(out_chan.data);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TIMEOUT after %0d cycles, %0d results pending", cycle_count,
             pending_status.size());
    $display("underfreq_load_shed_controller_top_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    script_row_t           row;
    logic [CFG_DATA_W-1:0] ft;
    logic [CFG_DATA_W-1:0] rt;
    logic [CFG_DATA_W-1:0] hd;
    logic [CFG_DATA_W-1:0] rn;
    int                    n_items;

    rst_n          <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.data   <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= '0;
    cfg_wdata      <= '0;
    reset_relay_shadow();

    // Directed rows: reset view, zero and extreme counts, first sample,
    // two samples in one tick, shedding down to nothing, recovery, maintenance
    script.push_back(typed_row(REQ_TICK, 16'h0000, 5'h1F,
                               5'h1F, 5'h1F, 5'h00, 1'b1, '0, '0));
    script.push_back(typed_row(REQ_TICK, 16'hFFFF, 5'h00,
                               5'h1F, 5'h00, 5'h00, 1'b1, '0, '0));
    script.push_back(typed_row(REQ_SAMPLE, 16'd0, 5'h15,
                               5'h1F, 5'h15, 5'h00, 1'b1, FREQ_SAT, '0));
    script.push_back(typed_row(REQ_SAMPLE, 16'd0, 5'h0A,
                               5'h1F, 5'h0A, 5'h00, 1'b1, FREQ_SAT, '0));
    script.push_back(typed_row(REQ_SAMPLE, 16'd1, 5'h1F,
                               5'h1E, 5'h1E, 5'h01, 1'b0, 22'd4096000, ROC_SAT));
    script.push_back(typed_row(REQ_SAMPLE, 16'hFFFF, 5'h1F,
                               5'h1E, 5'h1E, 5'h01, 1'b0, 22'd62, ROC_SAT));
    script.push_back(reg_row(CFG_HOLD, 24'd1));
    for (int k = 0; k < 5; k++) begin
      script.push_back(item_row(REQ_TICK, 16'd0, 5'h0F));
      script.push_back(item_row(REQ_TICK, 16'd0, 5'h10));
      script.push_back(item_row(REQ_SAMPLE, 16'd400, 5'h1F));
    end
    script.push_back(reg_row(CFG_ROC_TH, 24'hFFFFFF));
    script.push_back(item_row(REQ_TICK, 16'd0, 5'h1F));
    script.push_back(item_row(REQ_SAMPLE, 16'd320, 5'h1F));
    script.push_back(item_row(REQ_TICK, 16'd0, 5'h1F));
    script.push_back(item_row(REQ_TICK, 16'd0, 5'h1F));
    script.push_back(item_row(REQ_SAMPLE, 16'd320, 5'h1F));
    script.push_back(reg_row(CFG_RUN, 24'd0));
    script.push_back(item_row(REQ_SAMPLE, 16'd400, 5'h11));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      row = script[i];
      if (row.is_cfg) begin
        idle_input();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(row.idx, row.wdata);
      end else begin
        offer(row.item, row.typed, row.want);
      end
    end

    // Random phases, each under its own register setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      rn = 24'd1;
      case (phase)
        0: begin ft = 24'd12800; rt = 24'd200000; hd = 24'd3; end
        1: begin ft = 24'h3FFFFF; rt = 24'hFFFFFF; hd = 24'd1; end
        2: begin ft = 24'd0; rt = 24'd0; hd = 24'd2; end
        3: begin ft = 24'd12800; rt = 24'hFFFFFF; hd = 24'hFFFF; end
        4: begin ft = 24'd12800; rt = 24'd1280; hd = 24'd4; rn = 24'd0; end
        5: begin
          ft = CFG_DATA_W'($urandom_range(12000, 13600));
          rt = CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
          hd = CFG_DATA_W'($urandom_range(1, 8));
        end
        6: begin ft = 24'd12800; rt = 24'd5000000; hd = 24'd1; end
        default: begin
          ft = CFG_DATA_W'($urandom);
          rt = CFG_DATA_W'($urandom);
          hd = CFG_DATA_W'($urandom_range(1, 12));
        end
      endcase

      // Reprogram only once the block has gone quiet
      idle_input();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      write_reg(CFG_FREQ_TH, ft);
      write_reg(CFG_ROC_TH, rt);
      write_reg(CFG_HOLD, hd);
      write_reg(CFG_RUN, rn);

      // Center the sample counts on the threshold frequency
      nominal = (freq_limit == '0) ? 320 : int'(FREQ_NUM / DIV_W'(freq_limit));
      if (nominal < 8)
        nominal = 8;
      if (nominal > 65000)
        nominal = 65000;
      last_count = nominal;
      burst_mode = (phase == 6);
      n_items = (phase == 4) ? MAINT_ITEMS : ITEMS_PER_PHASE;

      for (int n = 0; n < n_items; n++) begin
        if (phase == 0 && n == 100)
          hold_off_req = 1'b1;
        if (phase == 5 && n == 120) begin
          idle_input();
          wait_for_results();
        end
        offer(draw_relay_item(), 1'b0, '0);
      end
    end

    // Drain and report
    idle_input();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_status.size() != 0)
      flag_mismatch("results never delivered", 32'(pending_status.size()), '0);
    if (mismatches == 0) begin
      $display("underfreq_load_shed_controller_top_tb: done, clean");
    end else begin
      $display("underfreq_load_shed_controller_top_tb: done, errors");
    end
    $finish;
  end

endmodule
